// ----- design/ffe_pkg.sv -----
// Shared types, codes and helpers of the form field extractor.
`timescale 1ns / 1ps

package ffe_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    localparam logic [7:0] RAW_LIMIT  = 8'd195;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;
    localparam logic [3:0] INDEX_MAX  = 4'hF;
    localparam logic [8:0] CAP_RESET  = 9'd1;

    typedef enum logic [1:0] {
        REG_KEY_NAME       = 2'd0,
        REG_KEY_LENGTH     = 2'd1,
        REG_VALUE_CAPACITY = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_VALUE = 2'd1,
        PH_SKIP  = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE   = 2'd0,
        ESC_FIRST  = 2'd1,
        ESC_SECOND = 2'd2
    } esc_t;

    // ST_FOUND doubles as "no reject recorded"
    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RAW_LONG  = 3'd2,
        ST_BAD_ESC   = 3'd3,
        ST_DEC_LONG  = 3'd4
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  key_index;
        logic        key_mismatch;
        esc_t        esc;
        logic [3:0]  high_nibble;
        logic [7:0]  raw_count;
        logic [7:0]  decoded_count;
        status_t     reject;
        logic        match_found;
    } body_state_t;

    localparam body_state_t BODY_RESET = '{
        phase:         PH_KEY,
        key_index:     4'd0,
        key_mismatch:  1'b0,
        esc:           ESC_NONE,
        high_nibble:   4'd0,
        raw_count:     8'd0,
        decoded_count: 8'd0,
        reject:        ST_FOUND,
        match_found:   1'b0
    };

    typedef struct packed {
        logic        valid;
        logic        last;
        status_t     status;
        logic [7:0]  value_byte;
    } result_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h61;
            r = {1'b1, d[3:0] + HEX_TEN};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h41;
            r = {1'b1, d[3:0] + HEX_TEN};
        end
        return r;
    endfunction

endpackage

// ----- design/form_field_extractor_top.sv -----
// Top level of the form field extractor: input register, parse step, result register.
`timescale 1ns / 1ps

// Takes a URL-encoded form body one byte per cycle on the slave stream, a zero byte
// ending each body, and streams out the decoded value of the first pair whose key equals
// key_name (key_length bytes). Each accepted byte is held in an input register, passed
// through a combinational parse and decode step, and any result lands in an output
// register, so a byte is accepted every cycle while the output is taken, and a result
// is presented on the master stream from the output register after its byte is parsed. Value bytes
// come out with tlast low; the terminator gives one item with tlast high carrying the
// status code. On any non-zero status the bytes already delivered for that body are to
// be discarded. Write the configuration only while no body is in flight.
module form_field_extractor_top
    import ffe_pkg::*;
#(
    parameter int NAME_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] body_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // [7:0] value_byte, [10:8] status, [15:11] zero
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic [NAME_BYTES*8-1:0] key_name;
    logic [3:0]              key_length;
    logic [8:0]              value_capacity;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    result_t    result;
    logic       out_free;
    logic       fire;
    logic       s_accept;

    ffe_cfg #(
        .NAME_BYTES (NAME_BYTES)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .key_name       (key_name),
        .key_length     (key_length),
        .value_capacity (value_capacity)
    );

    ffe_parse #(
        .NAME_BYTES (NAME_BYTES)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (fire),
        .body_byte      (in_byte_reg),
        .key_name       (key_name),
        .key_length     (key_length),
        .value_capacity (value_capacity),
        .result         (result)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? result.valid : (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_byte_reg <= s_axis_tdata;
        if (fire && result.valid)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {5'd0, out_reg.status, out_reg.value_byte};

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("held input item lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("empty input stage refuses an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == CH_END)
        else $error("status item carries a value byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:8] == ST_FOUND)
        else $error("value item carries a status code");

endmodule

// ----- design/ffe_cfg.sv -----
// Configuration register file of the form field extractor.
`timescale 1ns / 1ps

module ffe_cfg
    import ffe_pkg::*;
#(
    parameter int NAME_BYTES = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [63:0]               cfg_data,
    output logic [NAME_BYTES*8-1:0]   key_name,
    output logic [3:0]                key_length,
    output logic [8:0]                value_capacity
);

    logic [NAME_BYTES*8-1:0] key_name_reg;
    logic [3:0]              key_length_reg;
    logic [8:0]              value_capacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_name_reg       <= '0;
            key_length_reg     <= 4'd0;
            value_capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_NAME:       key_name_reg       <= cfg_data[NAME_BYTES*8-1:0];
                REG_KEY_LENGTH:     key_length_reg     <= cfg_data[3:0];
                REG_VALUE_CAPACITY: value_capacity_reg <= cfg_data[8:0];
                default:            ;
            endcase
        end
    end

    assign key_name       = key_name_reg;
    assign key_length     = key_length_reg;
    assign value_capacity = value_capacity_reg;

endmodule

// ----- design/ffe_parse.sv -----
// Per-byte parse and decode step with the body state register.
`timescale 1ns / 1ps

module ffe_parse
    import ffe_pkg::*;
#(
    parameter int NAME_BYTES = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                body_byte,
    input  logic [NAME_BYTES*8-1:0]   key_name,
    input  logic [3:0]                key_length,
    input  logic [8:0]                value_capacity,
    output result_t                   result
);

    body_state_t st_reg;
    body_state_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= BODY_RESET;
        else if (step)
            st_reg <= st_next;
    end

    always_comb
    begin
        logic [7:0] want;
        logic [7:0] raw_n;
        logic [4:0] nib;
        logic [7:0] b;
        logic       prod;
        status_t    rej;

        st_next = st_reg;
        result  = '0;
        want    = 8'd0;
        raw_n   = 8'd0;
        b       = 8'd0;
        prod    = 1'b0;
        rej     = st_reg.reject;
        nib     = hex_digit_value(body_byte);

        if (body_byte == CH_END)
        begin
            if (st_reg.phase == PH_VALUE && st_reg.esc != ESC_NONE && rej == ST_FOUND)
                rej = ST_BAD_ESC;
            result.valid = 1'b1;
            result.last  = 1'b1;
            if (value_capacity == 9'd0)
                result.status = ST_DEC_LONG;
            else if (!st_reg.match_found)
                result.status = ST_NOT_FOUND;
            else if (rej != ST_FOUND)
                result.status = rej;
            else if ({1'b0, st_reg.decoded_count} >= value_capacity)
                result.status = ST_DEC_LONG;
            else
                result.status = ST_FOUND;
            st_next = BODY_RESET;
        end
        else
        begin
            case (st_reg.phase)
                PH_KEY:
                begin
                    if (body_byte == CH_AMP)
                    begin
                        st_next.key_index    = 4'd0;
                        st_next.key_mismatch = 1'b0;
                    end
                    else if (body_byte == CH_EQ)
                    begin
                        if (!st_reg.key_mismatch && st_reg.key_index == key_length)
                        begin
                            st_next.match_found = 1'b1;
                            st_next.phase       = PH_VALUE;
                        end
                        else
                            st_next.phase = PH_SKIP;
                    end
                    else
                    begin
                        for (int i = 0; i < NAME_BYTES; i++)
                        begin
                            if (st_reg.key_index == 4'(i))
                                want = key_name[i*8 +: 8];
                        end
                        if (st_reg.key_index >= key_length
                            || st_reg.key_index >= 4'(NAME_BYTES)
                            || want != body_byte)
                            st_next.key_mismatch = 1'b1;
                        if (st_reg.key_index != INDEX_MAX)
                            st_next.key_index = st_reg.key_index + 4'd1;
                    end
                end
                PH_VALUE:
                begin
                    if (body_byte == CH_AMP)
                    begin
                        if (st_reg.esc != ESC_NONE)
                        begin
                            if (rej == ST_FOUND)
                                st_next.reject = ST_BAD_ESC;
                            st_next.esc = ESC_NONE;
                        end
                        st_next.phase = PH_DONE;
                    end
                    else
                    begin
                        raw_n = (st_reg.raw_count == COUNT_MAX) ? st_reg.raw_count
                                                                : st_reg.raw_count + 8'd1;
                        st_next.raw_count = raw_n;
                        if (raw_n >= RAW_LIMIT)
                            rej = ST_RAW_LONG;
                        st_next.reject = rej;
                        if (rej == ST_FOUND)
                        begin
                            case (st_reg.esc)
                                ESC_FIRST:
                                begin
                                    if (!nib[4])
                                    begin
                                        st_next.reject = ST_BAD_ESC;
                                        st_next.esc    = ESC_NONE;
                                    end
                                    else
                                    begin
                                        st_next.high_nibble = nib[3:0];
                                        st_next.esc         = ESC_SECOND;
                                    end
                                end
                                ESC_SECOND:
                                begin
                                    if (!nib[4] || (st_reg.high_nibble == 4'd0
                                                    && nib[3:0] == 4'd0))
                                    begin
                                        st_next.reject = ST_BAD_ESC;
                                        st_next.esc    = ESC_NONE;
                                    end
                                    else
                                    begin
                                        b           = {st_reg.high_nibble, nib[3:0]};
                                        st_next.esc = ESC_NONE;
                                        prod        = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    if (body_byte == CH_PCT)
                                        st_next.esc = ESC_FIRST;
                                    else if (body_byte == CH_PLUS)
                                    begin
                                        b    = CH_SPACE;
                                        prod = 1'b1;
                                    end
                                    else
                                    begin
                                        b    = body_byte;
                                        prod = 1'b1;
                                    end
                                end
                            endcase
                            if (prod)
                            begin
                                if (st_reg.decoded_count != COUNT_MAX)
                                    st_next.decoded_count = st_reg.decoded_count + 8'd1;
                                result.valid      = 1'b1;
                                result.value_byte = b;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (body_byte == CH_AMP)
                    begin
                        st_next.phase        = PH_KEY;
                        st_next.key_index    = 4'd0;
                        st_next.key_mismatch = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
